FILE: src/idpd_pkg.sv
// ----------------------------------------------------------------------------
// idpd_pkg
// shared constants, codes and control types of the decimal field formatter
// ----------------------------------------------------------------------------
`default_nettype none

package idpd_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned CNT_W      = 6;

  localparam int unsigned DEF_VALUE_BITS = 64;
  localparam int unsigned DEF_MAX_DIGITS = 20;
  localparam int unsigned DEF_MAX_FIELD  = 62;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGNED_MODE  = 3'd0,
    REG_SIGN_STYLE   = 3'd1,
    REG_LEFT_ALIGN   = 3'd2,
    REG_ZERO_PAD     = 3'd3,
    REG_MIN_WIDTH    = 3'd4,
    REG_DIGITS_GIVEN = 3'd5,
    REG_MIN_DIGITS   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_SPACE = 2'd2
  } sign_style_e;

  typedef enum logic [1:0] {
    EMIT_SPACE = 2'd0,
    EMIT_SIGN  = 2'd1,
    EMIT_ZERO  = 2'd2,
    EMIT_DIGIT = 2'd3
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      conv;
    logic      calc;
    logic      idx_dec;
    logic      cnt_dec;
    logic      cnt_zeros;
    logic      cnt_spaces;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
  } idpd_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic idx_zero;
    logic scan_hit;
    logic sign_nz;
    logic tail_pad;
    logic left_align;
    logic out_free;
  } idpd_status_t;

endpackage

`default_nettype wire

FILE: src/idpd_if.sv
// ----------------------------------------------------------------------------
// idpd_if
// request channels of the decimal field formatter: value in, characters out
// ----------------------------------------------------------------------------
`default_nettype none

interface idpd_in_if;
  import idpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface idpd_out_if;
  import idpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              is_last;

  modport source (output valid, output out_char, output is_last, input ready);
  modport sink   (input valid, input out_char, input is_last, output ready);
endinterface

`default_nettype wire

FILE: src/idpd_datapath.sv
// ----------------------------------------------------------------------------
// idpd_datapath
// config registers, bit-serial binary to bcd converter, pad counts, char output
// ----------------------------------------------------------------------------
`default_nettype none

module idpd_datapath #(
  parameter int unsigned VALUE_BITS = idpd_pkg::DEF_VALUE_BITS,
  parameter int unsigned MAX_DIGITS = idpd_pkg::DEF_MAX_DIGITS,
  parameter int unsigned MAX_FIELD  = idpd_pkg::DEF_MAX_FIELD
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [idpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [idpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [idpd_pkg::VALUE_W-1:0]   value_i,
  input  wire idpd_pkg::idpd_cmd_t            cmd_i,
  output idpd_pkg::idpd_status_t              status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [idpd_pkg::CHAR_W-1:0]         out_char_o,
  output logic                                out_last_o
);
  import idpd_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned SUM_W = CNT_W + 1;

  // configuration
  logic                  signed_mode_q;
  logic [1:0]            sign_style_q;
  logic                  left_align_q;
  logic                  zero_pad_q;
  logic [CFG_DATA_W-1:0] min_width_q;
  logic                  digits_given_q;
  logic [CFG_DATA_W-1:0] min_digits_q;

  // conversion
  logic [VALUE_BITS-1:0] mag_q;
  logic [3:0]            bcd_q [MAX_DIGITS];
  logic [3:0]            adj   [MAX_DIGITS];
  logic                  ovf_q;
  logic [CHAR_W-1:0]     sign_char_q;
  logic [CHAR_W-1:0]     sign_char_d;
  logic [VALUE_BITS-1:0] mag_load;
  logic                  neg;

  // counters and pad lengths
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] idx_d;
  logic [CNT_W-1:0] zeros_q;
  logic [CNT_W-1:0] spaces_q;

  logic [SUM_W-1:0] width_s;
  logic [SUM_W-1:0] prec_s;
  logic [SUM_W-1:0] len_s;
  logic [SUM_W-1:0] sl_s;
  logic [SUM_W-1:0] zeros_s;
  logic [SUM_W-1:0] body_s;
  logic [SUM_W-1:0] spaces_s;
  logic             zero_fill;

  // output register
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;
  logic [CHAR_W-1:0] emit_char;
  logic [3:0]        digit_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q  <= 1'b1;
      sign_style_q   <= SIGN_NONE;
      left_align_q   <= 1'b0;
      zero_pad_q     <= 1'b0;
      min_width_q    <= '0;
      digits_given_q <= 1'b0;
      min_digits_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SIGNED_MODE:  signed_mode_q  <= cfg_data_i[0];
        REG_SIGN_STYLE:   sign_style_q   <= cfg_data_i[1:0];
        REG_LEFT_ALIGN:   left_align_q   <= cfg_data_i[0];
        REG_ZERO_PAD:     zero_pad_q     <= cfg_data_i[0];
        REG_MIN_WIDTH:    min_width_q    <= cfg_data_i;
        REG_DIGITS_GIVEN: digits_given_q <= cfg_data_i[0];
        REG_MIN_DIGITS:   min_digits_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sign and magnitude at load
  always_comb begin
    neg      = signed_mode_q & value_i[VALUE_BITS-1];
    mag_load = neg ? ({VALUE_BITS{1'b0}} - value_i[VALUE_BITS-1:0])
                   : value_i[VALUE_BITS-1:0];
    priority if (neg) begin
      sign_char_d = CHAR_MINUS;
    end else if (signed_mode_q && sign_style_q == SIGN_PLUS) begin
      sign_char_d = CHAR_PLUS;
    end else if (signed_mode_q && sign_style_q == SIGN_SPACE) begin
      sign_char_d = CHAR_SPACE;
    end else begin
      sign_char_d = '0;
    end
  end

  // add-3 correction of every digit before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_load;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        bcd_q[i] <= 4'd0;
      end
    end else if (cmd_i.conv) begin
      mag_q    <= {mag_q[VALUE_BITS-2:0], 1'b0};
      bcd_q[0] <= {adj[0][2:0], mag_q[VALUE_BITS-1]};
      for (int i = 1; i < MAX_DIGITS; i++) begin
        bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  // pad lengths from the digit count
  always_comb begin
    width_s   = (min_width_q > CFG_DATA_W'(MAX_FIELD)) ? SUM_W'(MAX_FIELD)
                                                      : SUM_W'(min_width_q);
    prec_s    = (min_digits_q > CFG_DATA_W'(MAX_FIELD)) ? SUM_W'(MAX_FIELD)
                                                       : SUM_W'(min_digits_q);
    len_s     = SUM_W'(idx_q) + SUM_W'(1);
    sl_s      = SUM_W'(sign_char_q != '0);
    zero_fill = zero_pad_q & ~left_align_q & ~digits_given_q;
    zeros_s   = '0;
    if (digits_given_q) begin
      if (prec_s > len_s) begin
        zeros_s = prec_s - len_s;
      end
    end else if (zero_fill) begin
      if (width_s > len_s + sl_s) begin
        zeros_s = width_s - (len_s + sl_s);
      end
    end
    body_s   = len_s + zeros_s + sl_s;
    spaces_s = (!zero_fill && width_s > body_s) ? width_s - body_s : '0;
  end

  always_comb begin
    priority if (cmd_i.load) begin
      cnt_d = CNT_W'(VALUE_BITS - 1);
    end else if (cmd_i.calc) begin
      cnt_d = CNT_W'(spaces_s);
    end else if (cmd_i.cnt_zeros) begin
      cnt_d = zeros_q;
    end else if (cmd_i.cnt_spaces) begin
      cnt_d = spaces_q;
    end else if (cmd_i.conv || cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
    priority if (cmd_i.load) begin
      idx_d = IDX_W'(MAX_DIGITS - 1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IDX_W'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      sign_char_q <= '0;
      zeros_q     <= '0;
      spaces_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (cmd_i.load) begin
        ovf_q       <= 1'b0;
        sign_char_q <= sign_char_d;
      end else if (cmd_i.conv) begin
        ovf_q <= ovf_q | adj[MAX_DIGITS-1][3];
      end
      if (cmd_i.calc) begin
        zeros_q  <= CNT_W'(zeros_s);
        spaces_q <= CNT_W'(spaces_s);
      end
    end
  end

  // character select and output register
  assign digit_sel = bcd_q[idx_q];

  always_comb begin
    unique case (cmd_i.emit_sel)
      EMIT_SPACE: emit_char = CHAR_SPACE;
      EMIT_SIGN:  emit_char = sign_char_q;
      EMIT_ZERO:  emit_char = CHAR_ZERO;
      EMIT_DIGIT: emit_char = CHAR_ZERO + CHAR_W'(digit_sel);
      default:    emit_char = CHAR_SPACE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= emit_char;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    status_o.cnt_zero   = (cnt_q == '0);
    status_o.cnt_one    = (cnt_q == CNT_W'(1));
    status_o.idx_zero   = (idx_q == '0);
    status_o.scan_hit   = ovf_q | (digit_sel != 4'd0) | (idx_q == '0);
    status_o.sign_nz    = (sign_char_q != '0);
    status_o.tail_pad   = left_align_q & (spaces_q != '0);
    status_o.left_align = left_align_q;
    status_o.out_free   = ~out_valid_q | out_ready_i;
  end

endmodule

`default_nettype wire

FILE: src/idpd_ctrl.sv
// ----------------------------------------------------------------------------
// idpd_ctrl
// sequencer: convert, find digit count, size pads, then walk the field
// ----------------------------------------------------------------------------
`default_nettype none

module idpd_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire idpd_pkg::idpd_status_t status_i,
  output idpd_pkg::idpd_cmd_t         cmd_o
);
  import idpd_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CONV  = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_CALC  = 9'b000001000,
    ST_LEAD  = 9'b000010000,
    ST_SIGN  = 9'b000100000,
    ST_ZERO  = 9'b001000000,
    ST_DIGIT = 9'b010000000,
    ST_TAIL  = 9'b100000000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_hit) begin
          state_d = ST_CALC;
        end else begin
          cmd_o.idx_dec = 1'b1;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_LEAD;
      end
      ST_LEAD: begin
        if (status_i.left_align || status_i.cnt_zero) begin
          cmd_o.cnt_zeros = 1'b1;
          state_d         = ST_SIGN;
        end else if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_SPACE;
          cmd_o.cnt_dec  = 1'b1;
        end
      end
      ST_SIGN: begin
        if (!status_i.sign_nz) begin
          state_d = ST_ZERO;
        end else if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_SIGN;
          state_d        = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (status_i.cnt_zero) begin
          state_d = ST_DIGIT;
        end else if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_ZERO;
          cmd_o.cnt_dec  = 1'b1;
        end
      end
      ST_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_DIGIT;
          cmd_o.emit_last = status_i.idx_zero & ~status_i.tail_pad;
          if (status_i.idx_zero) begin
            cmd_o.cnt_spaces = 1'b1;
            state_d          = ST_TAIL;
          end else begin
            cmd_o.idx_dec = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (!status_i.left_align || status_i.cnt_zero) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_SPACE;
          cmd_o.emit_last = status_i.cnt_one;
          cmd_o.cnt_dec   = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/integer_to_padded_decimal.sv
// ----------------------------------------------------------------------------
// integer_to_padded_decimal
// printf style decimal field formatter, one ascii character per output request
// ----------------------------------------------------------------------------
// order: bcd converter loop, digit scan and pad sizing come before the first character, and the
//   bcd loop dominates; the field opens with lead spaces, the sign, zeros or digits as configured
// a new value is taken only once the sequencer is back in idle after the whole field;
//   characters go out one char/cycle while the output is free
// reset: asynchronous, config back to defaults, sequencer idle, output empty;
//   the digit store is written by every value and needs no clearing pass
`default_nettype none

module integer_to_padded_decimal #(
  parameter int unsigned VALUE_BITS = idpd_pkg::DEF_VALUE_BITS,
  parameter int unsigned MAX_DIGITS = idpd_pkg::DEF_MAX_DIGITS,
  parameter int unsigned MAX_FIELD  = idpd_pkg::DEF_MAX_FIELD
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration writes, register index as listed in idpd_pkg::cfg_reg_e
  input  wire logic                            cfg_we_i,
  input  wire logic [idpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [idpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // value requests in, character requests out
  idpd_in_if.sink                              value_ch_i,
  idpd_out_if.source                           char_ch_o
);
  import idpd_pkg::*;

  // command and status between sequencer and datapath
  idpd_cmd_t    cmd;
  idpd_status_t status;

  // sequencer: holds the phase of the field being printed
  // (convert, digit scan, pad sizing, lead spaces, sign, zeros, digits, tail)
  idpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (value_ch_i.valid),
    .in_ready_o (value_ch_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: config registers, double-dabble converter, digit store,
  // pad counters and the output register that decouples the sink
  idpd_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_ch_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (char_ch_o.valid),
    .out_ready_i (char_ch_o.ready),
    .out_char_o  (char_ch_o.out_char),
    .out_last_o  (char_ch_o.is_last)
  );

endmodule

`default_nettype wire

FILE: src/idpd_checker.sv
// ----------------------------------------------------------------------------
// idpd_checker
// port-level checks of the decimal field formatter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module idpd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [idpd_pkg::CHAR_W-1:0] out_char_i,
  input wire logic                        out_last_i
);
  import idpd_pkg::*;

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid_i & in_ready_i;
  assign out_fire = out_valid_i & out_ready_i;

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_last_i))
    else $error("stalled output character changed");

  // a new value is busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input ready right after taking a value");

  // no new value while the current field is still being printed
  a_no_take_mid_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a field");

  // a character still waiting when a value is taken must close its field
  a_take_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && out_valid_i |-> out_last_i)
    else $error("value taken while a field is unfinished");

endmodule

bind integer_to_padded_decimal idpd_checker u_idpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (value_ch_i.valid),
  .in_ready_i  (value_ch_i.ready),
  .out_valid_i (char_ch_o.valid),
  .out_ready_i (char_ch_o.ready),
  .out_char_i  (char_ch_o.out_char),
  .out_last_i  (char_ch_o.is_last)
);

`default_nettype wire
